/* rtl/core/touch_two_point_calibration_defines.svh */
// Assertion macros shared by the touch calibration design.
`ifndef TOUCH_TWO_POINT_CALIBRATION_DEFINES_SVH
`define TOUCH_TWO_POINT_CALIBRATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/tpc_pkg.sv */
// Shared types and constants for the touch calibration block.
package tpc_pkg;

	localparam int RawBits   = 10;
	localparam int SizeBits  = 12;
	localparam int CoefBits  = 24;
	localparam int AMagBits  = 32;
	localparam int BMagBits  = 24;
	localparam int ResBits   = AMagBits + BMagBits;
	localparam int CntBits   = 6;
	localparam int MulSteps  = BMagBits;
	localparam int DivSteps  = AMagBits;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} tpc_op_t;

	typedef struct packed {
		logic    go;
		tpc_op_t op;
	} tpc_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tpc_rsp_t;

endpackage

/* rtl/core/tpc_serial_unit.sv */
// Bit-serial unsigned multiplier and restoring divider shared by the datapath.
module tpc_serial_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpc_pkg::tpc_req_t             req,
	input  logic [tpc_pkg::AMagBits-1:0]  a_mag,
	input  logic [tpc_pkg::BMagBits-1:0]  b_mag,
	output tpc_pkg::tpc_rsp_t             rsp,
	output logic [tpc_pkg::ResBits-1:0]   res_mag
);
	import tpc_pkg::*;

	logic [ResBits-1:0]  acc_q;
	logic [AMagBits-1:0] mcand_q;
	logic [BMagBits-1:0] mplier_q;
	logic [BMagBits:0]   rem_q;
	logic [AMagBits-1:0] quo_q;
	logic [CntBits-1:0]  cnt_q;
	tpc_op_t             op_q;
	logic                busy_q;
	logic                done_q;

	logic [AMagBits:0]   mul_sum;
	logic [BMagBits:0]   rem_shift;
	logic [BMagBits+1:0] trial;

	// One partial product per cycle, shifting right.
	assign mul_sum = {1'b0, acc_q[ResBits-1:BMagBits]}
		+ (mplier_q[0] ? {1'b0, mcand_q} : '0);
	// One quotient bit per cycle.
	assign rem_shift = {rem_q[BMagBits-1:0], quo_q[AMagBits-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, b_mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == OP_DIV) ? CntBits'(DivSteps) : CntBits'(MulSteps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go && !busy_q) begin
			acc_q    <= '0;
			mcand_q  <= a_mag;
			mplier_q <= b_mag;
			rem_q    <= '0;
			quo_q    <= a_mag;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q    <= {mul_sum, acc_q[BMagBits-1:1]};
				mplier_q <= {1'b0, mplier_q[BMagBits-1:1]};
			end else begin
				if (!trial[BMagBits+1]) begin
					rem_q <= trial[BMagBits:0];
				end else begin
					rem_q <= rem_shift;
				end
				quo_q <= {quo_q[AMagBits-2:0], ~trial[BMagBits+1]};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign res_mag  = (op_q == OP_DIV) ? {{BMagBits{1'b0}}, quo_q} : acc_q;

endmodule

/* rtl/core/touch_two_point_calibration.sv */
// Steps after the input transfer: a start command places the first target, then the output
// stage; a plain sample takes two serial multiplies, then the output stage; a first calibration
// point also places the second target; the finishing point adds two distance multiplies, four
// product multiplies and four divisions before mapping. A stalled result delays the next item.
// Throughput: one item at a time; input is accepted only while the sequencer is idle.
// Reset: arst_n clears control, calibration state, offsets (0) and scales (1.0).
module touch_two_point_calibration (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// raw_x[9:0], raw_y[19:10], pressure[35:20], zero pad [39:36]
	input  logic [39:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// screen_x[15:0], screen_y[31:16], touch_valid[32], calibrating[33],
	// target_index[35:34], calibration_done[36], divide_error[37], zero pad [39:38]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [21:0] cfg_data
);
	import tpc_pkg::*;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ROT    = 3'd2;
	localparam logic [2:0] REG_PMIN   = 3'd3;
	localparam logic [2:0] REG_PMAX   = 3'd4;
	localparam logic [2:0] REG_SEP    = 3'd5;

	// Reciprocal of ten: floor(n * 52429 / 2^19) is exact for every n below 2^16.
	localparam logic [16:0] RECIP_TEN = 17'd52429;
	localparam logic [CoefBits-1:0] SCALE_ONE = 24'h010000;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TGT_X, ST_TGT_Y, ST_TGT_W,
		ST_DIST_X, ST_DIST_Y, ST_TAKE, ST_FIN_CHK,
		ST_FX_P1, ST_FX_P2, ST_FX_DIV,
		ST_FY_P1, ST_FY_P2, ST_FY_DIV,
		ST_SX_DIV, ST_SY_DIV, ST_MAP_X, ST_MAP_Y, ST_OUT
	} state_t;

	// Configuration registers.
	logic [SizeBits-1:0] width_q, height_q;
	logic [1:0]          rot_q;
	logic [15:0]         pmin_q, pmax_q;
	logic [21:0]         sep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd240;
			height_q <= 12'd320;
			rot_q    <= 2'd0;
			pmin_q   <= 16'd10;
			pmax_q   <= 16'd1000;
			sep_q    <= 22'd10000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[SizeBits-1:0];
				REG_HEIGHT: height_q <= cfg_data[SizeBits-1:0];
				REG_ROT:    rot_q    <= cfg_data[1:0];
				REG_PMIN:   pmin_q   <= cfg_data[15:0];
				REG_PMAX:   pmax_q   <= cfg_data[15:0];
				REG_SEP:    sep_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	state_t               state_q;
	logic                 wait_q;
	logic                 kind_q, valid_q, done_q, derr_q;
	logic [RawBits-1:0]   rx_q, ry_q;
	logic [1:0]           pc_q;
	logic                 cal_q;
	logic                 tidx_q;
	logic [RawBits-1:0]   stx_q [2];
	logic [RawBits-1:0]   sty_q [2];
	logic [SizeBits-1:0]  tx_q [2];
	logic [SizeBits-1:0]  ty_q [2];
	logic [SizeBits-1:0]  nx_q, ny_q;
	logic [CoefBits-1:0]  offx_q, offy_q, sclx_q, scly_q;
	logic [21:0]          dsq_q;
	logic [21:0]          p1_q, p2_q;
	logic [32:0]          ux_q, uy_q;
	logic                 out_valid_q;
	logic [39:0]          out_data_q;

	tpc_req_t             req;
	tpc_rsp_t             rsp;
	logic [AMagBits-1:0]  a_mag;
	logic [BMagBits-1:0]  b_mag;
	logic                 op_neg;
	logic [ResBits-1:0]   res_mag;

	tpc_serial_unit u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.a_mag   (a_mag),
		.b_mag   (b_mag),
		.rsp     (rsp),
		.res_mag (res_mag)
	);

	// Input fields and the pressure window.
	logic [RawBits-1:0] in_rx, in_ry;
	logic [15:0]        in_pr;
	logic               in_valid_pr;
	logic               in_accept;

	assign in_rx       = s_tdata[9:0];
	assign in_ry       = s_tdata[19:10];
	assign in_pr       = s_tdata[35:20];
	assign in_valid_pr = (in_pr > pmin_q) && (in_pr < pmax_q);
	assign s_tready    = (state_q == ST_IDLE);
	assign in_accept   = s_tvalid && s_tready;

	// Differences used by the separation check and the finish computation.
	logic               prev_idx;
	logic signed [10:0] dx, dy, drx, dry;
	logic signed [12:0] dtx, dty;
	logic [9:0]         dx_abs, dy_abs;
	logic [10:0]        drx_abs, dry_abs;
	logic [12:0]        dtx_abs, dty_abs;

	assign prev_idx = ~pc_q[0];
	assign dx  = $signed({1'b0, rx_q}) - $signed({1'b0, stx_q[prev_idx]});
	assign dy  = $signed({1'b0, ry_q}) - $signed({1'b0, sty_q[prev_idx]});
	assign drx = $signed({1'b0, stx_q[1]}) - $signed({1'b0, stx_q[0]});
	assign dry = $signed({1'b0, sty_q[1]}) - $signed({1'b0, sty_q[0]});
	assign dtx = $signed({1'b0, tx_q[1]}) - $signed({1'b0, tx_q[0]});
	assign dty = $signed({1'b0, ty_q[1]}) - $signed({1'b0, ty_q[0]});
	assign dx_abs  = dx[10] ? 10'(-dx) : dx[9:0];
	assign dy_abs  = dy[10] ? 10'(-dy) : dy[9:0];
	assign drx_abs = drx[10] ? 11'(-drx) : 11'(drx);
	assign dry_abs = dry[10] ? 11'(-dry) : 11'(dry);
	assign dtx_abs = dtx[12] ? 13'(-dtx) : 13'(dtx);
	assign dty_abs = dty[12] ? 13'(-dty) : 13'(dty);

	// Finish numerator: (t0*r1 - t1*r0) * 256, taken from the two stored products.
	logic signed [30:0] num;
	logic [30:0]        num_abs;

	assign num     = 31'($signed({1'b0, p1_q}) - $signed({1'b0, p2_q})) <<< 8;
	assign num_abs = num[30] ? 31'(-num) : num;

	// Mapping sum raw * 256 + offset for whichever axis is under way.
	logic signed [24:0] map_sum;
	logic [24:0]        map_abs;
	logic [CoefBits-1:0] map_off, map_scl, scl_abs;
	logic [RawBits-1:0]  map_raw;

	assign map_raw = (state_q == ST_MAP_Y) ? ry_q : rx_q;
	assign map_off = (state_q == ST_MAP_Y) ? offy_q : offx_q;
	assign map_scl = (state_q == ST_MAP_Y) ? scly_q : sclx_q;
	assign map_sum = $signed({7'b0, map_raw, 8'b0}) + $signed({map_off[CoefBits-1], map_off});
	assign map_abs = map_sum[24] ? 25'(-map_sum) : map_sum;
	assign scl_abs = map_scl[CoefBits-1] ? CoefBits'(-$signed(map_scl)) : map_scl;

	// Operands of the shared unit, chosen by the step in progress.
	logic is_op_state;

	always_comb begin
		a_mag       = '0;
		b_mag       = '0;
		op_neg      = 1'b0;
		req.op      = OP_MUL;
		is_op_state = 1'b1;
		case (state_q)
			ST_DIST_X: begin
				a_mag = AMagBits'(dx_abs);
				b_mag = BMagBits'(dx_abs);
			end
			ST_DIST_Y: begin
				a_mag = AMagBits'(dy_abs);
				b_mag = BMagBits'(dy_abs);
			end
			ST_FX_P1: begin
				a_mag = AMagBits'(tx_q[0]);
				b_mag = BMagBits'(stx_q[1]);
			end
			ST_FX_P2: begin
				a_mag = AMagBits'(tx_q[1]);
				b_mag = BMagBits'(stx_q[0]);
			end
			ST_FY_P1: begin
				a_mag = AMagBits'(ty_q[0]);
				b_mag = BMagBits'(sty_q[1]);
			end
			ST_FY_P2: begin
				a_mag = AMagBits'(ty_q[1]);
				b_mag = BMagBits'(sty_q[0]);
			end
			ST_FX_DIV: begin
				req.op = OP_DIV;
				a_mag  = AMagBits'(num_abs);
				b_mag  = BMagBits'(dtx_abs);
				op_neg = num[30] ^ dtx[12];
			end
			ST_FY_DIV: begin
				req.op = OP_DIV;
				a_mag  = AMagBits'(num_abs);
				b_mag  = BMagBits'(dty_abs);
				op_neg = num[30] ^ dty[12];
			end
			ST_SX_DIV: begin
				req.op = OP_DIV;
				a_mag  = AMagBits'({dtx_abs, 16'b0});
				b_mag  = BMagBits'(drx_abs);
				op_neg = dtx[12] ^ drx[10];
			end
			ST_SY_DIV: begin
				req.op = OP_DIV;
				a_mag  = AMagBits'({dty_abs, 16'b0});
				b_mag  = BMagBits'(dry_abs);
				op_neg = dty[12] ^ dry[10];
			end
			ST_MAP_X, ST_MAP_Y: begin
				a_mag  = AMagBits'(map_abs);
				b_mag  = scl_abs;
				op_neg = map_sum[24] ^ map_scl[CoefBits-1];
			end
			default: is_op_state = 1'b0;
		endcase
		req.go = is_op_state && !wait_q;
	end

	// Signed quotient, saturated to the 24-bit coefficient range.
	function automatic logic [CoefBits-1:0] sat_coef(input logic neg,
		input logic [AMagBits-1:0] mag);
		logic [CoefBits-1:0] r;
		begin
			if (!neg) begin
				r = (mag > AMagBits'(24'h7FFFFF)) ? 24'h7FFFFF : mag[CoefBits-1:0];
			end else begin
				r = (mag > AMagBits'(24'h800000)) ? 24'h800000
					: CoefBits'(-$signed({1'b0, mag[CoefBits-1:0]}));
			end
			return r;
		end
	endfunction

	// Saturation of a rotated coordinate to int16.
	function automatic logic [15:0] sat16(input logic signed [34:0] v);
		logic [15:0] r;
		begin
			if (v > 35'sd32767) begin
				r = 16'h7FFF;
			end else if (v < -35'sd32768) begin
				r = 16'h8000;
			end else begin
				r = v[15:0];
			end
			return r;
		end
	endfunction

	// Mapped magnitude is the product divided by 2^24; the sign is applied after
	// the shift so the result truncates toward zero.
	logic [31:0] map_q;
	logic [32:0] map_signed;

	assign map_q      = res_mag[ResBits-1:BMagBits];
	assign map_signed = op_neg ? 33'(-$signed({1'b0, map_q})) : {1'b0, map_q};

	// Target placement: one tenth or nine tenths of the screen size.
	logic [15:0] tgt_n;
	logic [32:0] tgt_prod;
	logic [SizeBits-1:0] tgt_x_rot, tgt_y_rot;

	assign tgt_n    = (state_q == ST_TGT_Y)
		? (tidx_q ? 16'(height_q) * 16'd9 : 16'(height_q))
		: (tidx_q ? 16'(width_q) * 16'd9 : 16'(width_q));
	assign tgt_prod = 33'(tgt_n) * 33'(RECIP_TEN);

	always_comb begin
		tgt_x_rot = nx_q;
		tgt_y_rot = ny_q;
		case (rot_q)
			2'd1: begin
				tgt_x_rot = height_q - 12'd1 - ny_q;
				tgt_y_rot = nx_q;
			end
			2'd2: begin
				tgt_x_rot = width_q - 12'd1 - nx_q;
				tgt_y_rot = height_q - 12'd1 - ny_q;
			end
			2'd3: begin
				tgt_x_rot = ny_q;
				tgt_y_rot = width_q - 12'd1 - nx_q;
			end
			default: ;
		endcase
	end

	// Screen rotation of the mapped point, then saturation.
	logic signed [34:0] ux_w, uy_w, wm1, hm1, rot_x, rot_y;

	assign ux_w = 35'($signed(ux_q));
	assign uy_w = 35'($signed(uy_q));
	assign wm1  = $signed({23'b0, width_q}) - 35'sd1;
	assign hm1  = $signed({23'b0, height_q}) - 35'sd1;

	always_comb begin
		rot_x = ux_w;
		rot_y = uy_w;
		case (rot_q)
			2'd1: begin
				rot_x = uy_w;
				rot_y = hm1 - ux_w;
			end
			2'd2: begin
				rot_x = wm1 - ux_w;
				rot_y = hm1 - uy_w;
			end
			2'd3: begin
				rot_x = wm1 - uy_w;
				rot_y = ux_w;
			end
			default: ;
		endcase
	end

	logic [15:0] sx_out, sy_out;
	logic [1:0]  tidx_out;
	logic        any_zero;
	logic [21:0] dsq_sum;

	assign sx_out   = kind_q ? 16'd0 : sat16(rot_x);
	assign sy_out   = kind_q ? 16'd0 : sat16(rot_y);
	assign tidx_out = cal_q ? pc_q : 2'd2;
	assign any_zero = (dtx == '0) || (dty == '0) || (drx == '0) || (dry == '0);
	assign dsq_sum  = dsq_q + res_mag[21:0];

	// Main sequencer. Each unit step launches the serial unit once, then waits
	// for its done pulse and takes the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			pc_q        <= 2'd0;
			cal_q       <= 1'b0;
			tidx_q      <= 1'b0;
			offx_q      <= '0;
			offy_q      <= '0;
			sclx_q      <= SCALE_ONE;
			scly_q      <= SCALE_ONE;
			kind_q      <= 1'b0;
			valid_q     <= 1'b0;
			done_q      <= 1'b0;
			derr_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// In the output state the result register is handled below.
			if (out_valid_q && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (req.go) begin
				wait_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						kind_q  <= s_tuser;
						rx_q    <= in_rx;
						ry_q    <= in_ry;
						done_q  <= 1'b0;
						derr_q  <= 1'b0;
						valid_q <= !s_tuser && in_valid_pr;
						if (s_tuser) begin
							pc_q    <= 2'd0;
							cal_q   <= 1'b1;
							tidx_q  <= 1'b0;
							state_q <= ST_TGT_X;
						end else if (cal_q && in_valid_pr) begin
							state_q <= (pc_q != 2'd0) ? ST_DIST_X : ST_TAKE;
						end else begin
							state_q <= ST_MAP_X;
						end
					end
				end
				ST_TGT_X: begin
					nx_q    <= tgt_prod[30:19];
					state_q <= ST_TGT_Y;
				end
				ST_TGT_Y: begin
					ny_q    <= tgt_prod[30:19];
					state_q <= ST_TGT_W;
				end
				ST_TGT_W: begin
					tx_q[tidx_q] <= tgt_x_rot;
					ty_q[tidx_q] <= tgt_y_rot;
					state_q      <= kind_q ? ST_OUT : ST_MAP_X;
				end
				ST_DIST_X: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						dsq_q   <= res_mag[21:0];
						state_q <= ST_DIST_Y;
					end
				end
				ST_DIST_Y: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						state_q <= (dsq_sum > sep_q) ? ST_TAKE : ST_MAP_X;
					end
				end
				ST_TAKE: begin
					stx_q[pc_q[0]] <= rx_q;
					sty_q[pc_q[0]] <= ry_q;
					pc_q           <= pc_q + 2'd1;
					if (pc_q != 2'd0) begin
						cal_q   <= 1'b0;
						state_q <= ST_FIN_CHK;
					end else begin
						tidx_q  <= 1'b1;
						state_q <= ST_TGT_X;
					end
				end
				ST_FIN_CHK: begin
					if (any_zero) begin
						derr_q  <= 1'b1;
						state_q <= ST_MAP_X;
					end else begin
						state_q <= ST_FX_P1;
					end
				end
				ST_FX_P1, ST_FY_P1: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						p1_q    <= res_mag[21:0];
						state_q <= (state_q == ST_FX_P1) ? ST_FX_P2 : ST_FY_P2;
					end
				end
				ST_FX_P2, ST_FY_P2: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						p2_q    <= res_mag[21:0];
						state_q <= (state_q == ST_FX_P2) ? ST_FX_DIV : ST_FY_DIV;
					end
				end
				ST_FX_DIV: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						offx_q  <= sat_coef(op_neg, res_mag[AMagBits-1:0]);
						state_q <= ST_FY_P1;
					end
				end
				ST_FY_DIV: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						offy_q  <= sat_coef(op_neg, res_mag[AMagBits-1:0]);
						state_q <= ST_SX_DIV;
					end
				end
				ST_SX_DIV: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						sclx_q  <= sat_coef(op_neg, res_mag[AMagBits-1:0]);
						state_q <= ST_SY_DIV;
					end
				end
				ST_SY_DIV: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						scly_q  <= sat_coef(op_neg, res_mag[AMagBits-1:0]);
						done_q  <= 1'b1;
						state_q <= ST_MAP_X;
					end
				end
				ST_MAP_X: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						ux_q    <= map_signed;
						state_q <= ST_MAP_Y;
					end
				end
				ST_MAP_Y: begin
					if (wait_q && rsp.done) begin
						wait_q  <= 1'b0;
						uy_q    <= map_signed;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// The result register frees up when its transfer completes.
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {2'b00, derr_q, done_q, tidx_out, cal_q, valid_q,
							sy_out, sx_out};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`include "touch_two_point_calibration_defines.svh"

	`TPC_ASSERT_NOW(a_pc_active, cal_q, pc_q < 2'd2, "point count reached two while calibrating")
	`TPC_ASSERT_NOW(a_unit_free, req.go, !rsp.busy, "serial unit launched while busy")
	`TPC_ASSERT_NOW(a_done_excl, out_valid_q, !(out_data_q[36] && out_data_q[37]), "done and divide error together")
	`TPC_ASSERT_NEXT(a_accept_busy, in_accept, state_q != ST_IDLE, "sequencer stayed idle after input transfer")

endmodule

/* tb/tpc_tb_pkg.sv */
// Register indexes, item kinds and the result layout shared by the calibration testbench.
`timescale 1ns / 100ps
package tpc_tb_pkg;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_ROTATION,
		REG_PRESSURE_MIN,
		REG_PRESSURE_MAX,
		REG_MIN_SEPARATION
	} tpc_reg_t;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_START  = 1'b1;

	// Result word as it travels on m_tdata, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]         pad;
		logic               divide_error;
		logic               calibration_done;
		logic [1:0]         target_index;
		logic               calibrating;
		logic               touch_valid;
		logic signed [15:0] screen_y;
		logic signed [15:0] screen_x;
	} tpc_result_t;

endpackage

/* tb/tpc_calibration_checker.sv */
// Checker that predicts every calibration result and compares it with the block's output.
`timescale 1ns / 100ps
module tpc_calibration_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [21:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          cal_done_seen,
	output int          div_err_seen
);
	import tpc_tb_pkg::*;

	logic [11:0] width, height;
	logic [1:0]  rot;
	logic [15:0] p_min, p_max;
	logic [21:0] min_sep;
	logic [1:0]  points;
	logic        active;
	logic [9:0]  touch_x[2], touch_y[2];
	logic [11:0] tgt_x[2], tgt_y[2];
	longint      off_x, off_y, scl_x, scl_y;

	tpc_result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Target placement is done in 32-bit unsigned arithmetic and kept modulo 2^12.
	function automatic void place_target(int idx);
		logic [31:0] w, h, x, y, ux, uy;
		w = {20'b0, width};
		h = {20'b0, height};
		x = (idx == 0) ? w / 10 : (w * 9) / 10;
		y = (idx == 0) ? h / 10 : (h * 9) / 10;
		ux = x;
		uy = y;
		case (rot)
			2'd1: begin ux = h - 1 - y; uy = x; end
			2'd2: begin ux = w - 1 - x; uy = h - 1 - y; end
			2'd3: begin ux = y; uy = w - 1 - x; end
			default: ;
		endcase
		tgt_x[idx] = ux[11:0];
		tgt_y[idx] = uy[11:0];
	endfunction

	function automatic longint map_axis(logic [9:0] raw, longint off, longint scl);
		longint p;
		p = (longint'({54'b0, raw}) * 256 + off) * scl;
		return (p < 0) ? -((-p) >>> 24) : (p >>> 24);
	endfunction

	// Solves both axes from the two stored points; a zero divisor keeps the old values.
	function automatic bit solve_coefficients();
		longint t0x, t1x, t0y, t1y, r0x, r1x, r0y, r1y, dtx, dty, drx, dry;
		t0x = {52'b0, tgt_x[0]};
		t1x = {52'b0, tgt_x[1]};
		t0y = {52'b0, tgt_y[0]};
		t1y = {52'b0, tgt_y[1]};
		r0x = {54'b0, touch_x[0]};
		r1x = {54'b0, touch_x[1]};
		r0y = {54'b0, touch_y[0]};
		r1y = {54'b0, touch_y[1]};
		dtx = t1x - t0x;
		dty = t1y - t0y;
		drx = r1x - r0x;
		dry = r1y - r0y;
		if (dtx == 0 || dty == 0 || drx == 0 || dry == 0)
			return 1'b0;
		off_x = clamp(((t0x * r1x - t1x * r0x) * 256) / dtx, -8388608, 8388607);
		off_y = clamp(((t0y * r1y - t1y * r0y) * 256) / dty, -8388608, 8388607);
		scl_x = clamp((dtx * 65536) / drx, -8388608, 8388607);
		scl_y = clamp((dty * 65536) / dry, -8388608, 8388607);
		return 1'b1;
	endfunction

	function automatic tpc_result_t predict_result(logic kind, logic [39:0] data);
		tpc_result_t r;
		logic [9:0]  rx, ry;
		logic [15:0] pr;
		logic        take;
		longint      dx, dy, ux, uy, sx, sy, w, h;
		rx = data[9:0];
		ry = data[19:10];
		pr = data[35:20];
		r = '0;
		if (kind == KIND_START) begin
			points = 2'd0;
			active = 1'b1;
			place_target(0);
		end else begin
			r.touch_valid = (pr > p_min) && (pr < p_max);
			if (active && r.touch_valid) begin
				take = 1'b1;
				if (points != 0) begin
					dx = longint'({54'b0, rx}) - longint'({54'b0, touch_x[0]});
					dy = longint'({54'b0, ry}) - longint'({54'b0, touch_y[0]});
					take = (dx * dx + dy * dy) > longint'({42'b0, min_sep});
				end
				if (take) begin
					touch_x[points[0]] = rx;
					touch_y[points[0]] = ry;
					points = points + 1;
					if (points >= 2) begin
						active = 1'b0;
						if (solve_coefficients())
							r.calibration_done = 1'b1;
						else
							r.divide_error = 1'b1;
					end else begin
						place_target(1);
					end
				end
			end
			// Mapping uses the coefficients in force after this item.
			ux = map_axis(rx, off_x, scl_x);
			uy = map_axis(ry, off_y, scl_y);
			w = {52'b0, width};
			h = {52'b0, height};
			case (rot)
				2'd1: begin sx = uy; sy = h - 1 - ux; end
				2'd2: begin sx = w - 1 - ux; sy = h - 1 - uy; end
				2'd3: begin sx = w - 1 - uy; sy = ux; end
				default: begin sx = ux; sy = uy; end
			endcase
			r.screen_x = 16'(clamp(sx, -32768, 32767));
			r.screen_y = 16'(clamp(sy, -32768, 32767));
		end
		r.calibrating = active;
		r.target_index = active ? points : 2'd2;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on result %0d: %s is %0d, expected %0d",
			results_seen, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tpc_result_t got, want;
		if (!arst_n) begin
			width = 12'd240;
			height = 12'd320;
			rot = 2'd0;
			p_min = 16'd10;
			p_max = 16'd1000;
			min_sep = 22'd10000;
			points = 2'd0;
			active = 1'b0;
			off_x = 0;
			off_y = 0;
			scl_x = 65536;
			scl_y = 65536;
			errors = 0;
			results_seen = 0;
			cal_done_seen = 0;
			div_err_seen = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				case (tpc_reg_t'(cfg_index))
					REG_WIDTH:          width = cfg_data[11:0];
					REG_HEIGHT:         height = cfg_data[11:0];
					REG_ROTATION:       rot = cfg_data[1:0];
					REG_PRESSURE_MIN:   p_min = cfg_data[15:0];
					REG_PRESSURE_MAX:   p_max = cfg_data[15:0];
					REG_MIN_SEPARATION: min_sep = cfg_data;
					default: ;
				endcase
			end
			// Results are checked before the new input is predicted, so a result and
			// the next input transfer on the same edge stay in order.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					$display("result %0d arrived with nothing expected", results_seen);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.screen_x !== want.screen_x)
						report_mismatch("screen_x", got.screen_x, want.screen_x);
					if (got.screen_y !== want.screen_y)
						report_mismatch("screen_y", got.screen_y, want.screen_y);
					if (got.touch_valid !== want.touch_valid)
						report_mismatch("touch_valid", got.touch_valid, want.touch_valid);
					if (got.calibrating !== want.calibrating)
						report_mismatch("calibrating", got.calibrating, want.calibrating);
					if (got.target_index !== want.target_index)
						report_mismatch("target_index", got.target_index, want.target_index);
					if (got.calibration_done !== want.calibration_done)
						report_mismatch("calibration_done", got.calibration_done,
							want.calibration_done);
					if (got.divide_error !== want.divide_error)
						report_mismatch("divide_error", got.divide_error, want.divide_error);
					if (want.calibration_done)
						cal_done_seen++;
					if (want.divide_error)
						div_err_seen++;
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_result(s_tuser, s_tdata));
		end
	end

endmodule

/* tb/touch_two_point_calibration_test.sv */
// Top of the calibration testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps
module touch_two_point_calibration_test;
	import tpc_tb_pkg::*;

	// Limit on the total cycle count of the run, checked by the watchdog.
	localparam int CycleLimit = 3000000;
	// Cycles to wait past the last result before touching registers or stopping.
	localparam int SettleCycles = 400;
	localparam int RandomItems = 2000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [21:0] cfg_data;

	int  errors, pending, results_seen, cal_done_seen, div_err_seen;
	int  items_sent;
	int  cycles;
	// When set, neither side inserts idle cycles.
	bit  no_idle;

	// Shadow copy of the pressure window, used only to aim samples at it.
	logic [15:0] win_lo, win_hi;

	touch_two_point_calibration DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tpc_calibration_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.results_seen  (results_seen),
		.cal_done_seen (cal_done_seen),
		.div_err_seen  (div_err_seen)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_SAMPLE;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_idle = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("** touch_two_point_calibration: FAILED **");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 17);
	endfunction

	// Receiver: stalls a random number of cycles before each result, then takes it.
	// Readiness is judged at the falling edge, where all outputs have settled.
	initial begin
		int  gap;
		bit  taken;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			taken = 1'b0;
			while (!taken) begin
				@(negedge clk);
				taken = m_tvalid;
				@(posedge clk);
			end
		end
	end

	// One input transfer. After the accepting edge the caller is still at that edge,
	// so valid is lowered only when a gap follows and never twice in one step.
	task automatic send_item(logic kind, logic [9:0] rx, logic [9:0] ry, logic [15:0] pr);
		int gap;
		bit taken;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {4'b0, pr, ry, rx};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		items_sent++;
	endtask

	// Sender holds off until every expected result has come and the block is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(tpc_reg_t idx, logic [21:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PRESSURE_MIN)
			win_lo = value[15:0];
		if (idx == REG_PRESSURE_MAX)
			win_hi = value[15:0];
	endtask

	task automatic write_all(logic [11:0] w, logic [11:0] h, logic [1:0] r,
			logic [15:0] lo, logic [15:0] hi, logic [21:0] sep);
		write_reg(REG_WIDTH, 22'(w));
		write_reg(REG_HEIGHT, 22'(h));
		write_reg(REG_ROTATION, 22'(r));
		write_reg(REG_PRESSURE_MIN, 22'(lo));
		write_reg(REG_PRESSURE_MAX, 22'(hi));
		write_reg(REG_MIN_SEPARATION, sep);
	endtask

	// A pressure inside the window when the window is open, anything otherwise.
	function automatic logic [15:0] good_pressure();
		if (win_hi > win_lo + 1)
			return 16'($urandom_range(win_lo + 1, win_hi - 1));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] any_pressure();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, win_lo));
			1: return 16'($urandom_range(win_hi, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	// One calibration attempt: start, noise, a first point, maybe a too-close point and noise,
	// then one to three second points, mostly far off, and more noise.
	task automatic calibration_sequence();
		logic [9:0] x0, y0;
		int         n;
		send_item(KIND_START, 10'($urandom), 10'($urandom), 16'($urandom));
		n = $urandom_range(0, 2);
		repeat (n)
			send_item(KIND_SAMPLE, 10'($urandom), 10'($urandom), any_pressure());
		if ($urandom_range(0, 9) == 0)
			send_item(KIND_START, 10'($urandom), 10'($urandom), 16'($urandom));
		x0 = 10'($urandom_range(0, 300));
		y0 = 10'($urandom);
		send_item(KIND_SAMPLE, x0, y0, good_pressure());
		// A point right next to the first one, turned down when the minimum separation is 9 or more.
		if ($urandom_range(0, 2) == 0)
			send_item(KIND_SAMPLE, x0 + 10'($urandom_range(0, 3)), y0, good_pressure());
		if ($urandom_range(0, 3) == 0)
			send_item(KIND_SAMPLE, 10'($urandom), 10'($urandom), any_pressure());
		n = $urandom_range(1, 3);
		repeat (n) begin
			// Occasionally share an axis with the first point to hit a zero divisor.
			if ($urandom_range(0, 7) == 0)
				send_item(KIND_SAMPLE, x0, 10'($urandom), good_pressure());
			else
				send_item(KIND_SAMPLE, 10'($urandom_range(500, 1023)), 10'($urandom),
					good_pressure());
		end
		n = $urandom_range(0, 4);
		repeat (n)
			send_item(KIND_SAMPLE, 10'($urandom), 10'($urandom), any_pressure());
	endtask

	initial begin
		int phase;
		cycles = 0;
		items_sent = 0;
		win_lo = 16'd10;
		win_hi = 16'd1000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at reset settings: pressure edges and raw extremes while idle.
		send_item(KIND_SAMPLE, 10'd0, 10'd0, 16'd0);
		send_item(KIND_SAMPLE, 10'd1023, 10'd1023, 16'd65535);
		send_item(KIND_SAMPLE, 10'd512, 10'd0, 16'd10);
		send_item(KIND_SAMPLE, 10'd0, 10'd1023, 16'd11);
		send_item(KIND_SAMPLE, 10'd1023, 10'd0, 16'd999);
		send_item(KIND_SAMPLE, 10'd341, 10'd682, 16'd1000);
		// A normal calibration, with a bad-pressure and a too-close point on the way.
		send_item(KIND_START, 10'd0, 10'd0, 16'd0);
		send_item(KIND_SAMPLE, 10'd100, 10'd100, 16'd5000);
		send_item(KIND_SAMPLE, 10'd100, 10'd100, 16'd500);
		send_item(KIND_SAMPLE, 10'd150, 10'd150, 16'd500);
		send_item(KIND_SAMPLE, 10'd900, 10'd900, 16'd500);
		send_item(KIND_SAMPLE, 10'd0, 10'd0, 16'd500);
		send_item(KIND_SAMPLE, 10'd1023, 10'd1023, 16'd500);
		// A restart in the middle, then an equal raw y that gives a zero divisor.
		send_item(KIND_START, 10'd1023, 10'd1023, 16'd65535);
		send_item(KIND_SAMPLE, 10'd200, 10'd300, 16'd500);
		send_item(KIND_START, 10'd0, 10'd0, 16'd0);
		send_item(KIND_SAMPLE, 10'd100, 10'd500, 16'd500);
		send_item(KIND_SAMPLE, 10'd900, 10'd500, 16'd500);
		send_item(KIND_SAMPLE, 10'd600, 10'd700, 16'd500);

		// Random part: phases of calibration sequences, each under new settings.
		phase = 0;
		while (items_sent < RandomItems + 20) begin
			drain();
			case (phase % 6)
				0: write_all(12'd4095, 12'd4095, 2'd3, 16'd0, 16'd65535, 22'd0);
				1: write_all(12'd1, 12'd1, 2'd2, 16'd65535, 16'd0, 22'd2097152);
				2: write_all(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
					2'($urandom), 16'($urandom_range(0, 200)),
					16'($urandom_range(500, 65535)), 22'($urandom_range(0, 300000)));
				3: write_all(12'($urandom_range(1, 40)), 12'($urandom_range(1, 40)),
					2'($urandom), 16'($urandom_range(0, 100)),
					16'($urandom_range(200, 2000)), 22'($urandom_range(0, 2000)));
				default: write_all(12'($urandom_range(1, 4095)),
					12'($urandom_range(1, 4095)), 2'($urandom), 16'($urandom),
					16'($urandom), 22'($urandom_range(0, 2097152)));
			endcase
			no_idle = (phase % 4 == 3);
			repeat (25) begin
				if ($urandom_range(0, 4) == 0)
					send_item(KIND_SAMPLE, 10'($urandom), 10'($urandom), 16'($urandom));
				else
					calibration_sequence();
			end
			phase++;
		end

		drain();
		$display("sent %0d items over %0d setting phases, checked %0d results", items_sent,
			phase, results_seen);
		$display("calibrations finished: %0d, stopped on a zero divisor: %0d",
			cal_done_seen, div_err_seen);
		if (errors == 0)
			$display("** touch_two_point_calibration: PASSED **");
		else
			$display("** touch_two_point_calibration: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tpc_pkg.sv
rtl/core/tpc_serial_unit.sv
rtl/core/touch_two_point_calibration.sv
tb/tpc_tb_pkg.sv
tb/tpc_calibration_checker.sv
tb/touch_two_point_calibration_test.sv
